// ----- rtl/scalar_to_rgb_pseudocolor_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the scalar-to-RGB pseudocolor unit.
// Both macros use the clk and rst_n of the module that expands them.
// ----------------------------------------------------------------------------
`ifndef SCALAR_TO_RGB_PSEUDOCOLOR_UNIT_ASSERT_SVH
`define SCALAR_TO_RGB_PSEUDOCOLOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STRGB_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STRGB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/strgb_pkg.sv -----
// ----------------------------------------------------------------------------
// strgb_pkg
// Shared constants and types of the scalar-to-RGB pseudocolor unit.
// ----------------------------------------------------------------------------
`default_nettype none

package strgb_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int COLOR_BITS_DEF  = 8;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_MIN = 1'b0,
        REG_RANGE_MAX = 1'b1
    } cfg_reg_t;

    localparam logic [63:0] RANGE_MIN_RESET = 64'd0;
    localparam logic [63:0] RANGE_MAX_RESET = 64'd65536;

    localparam int POS_FRAC = 20;
    localparam int POS_W    = POS_FRAC + 1;
    localparam int HN_W     = POS_W + 3;
    localparam int REM_W    = POS_FRAC + 2;
    localparam int SECTOR_W = 2;

    localparam int SECTOR_DEN_INT = 3 * (2 ** POS_FRAC);
    localparam logic [HN_W-1:0] SECTOR_DEN_1 = HN_W'(SECTOR_DEN_INT);
    localparam logic [HN_W-1:0] SECTOR_DEN_2 = HN_W'(2 * SECTOR_DEN_INT);
    localparam logic [HN_W-1:0] SECTOR_DEN_3 = HN_W'(3 * SECTOR_DEN_INT);

    localparam int LEVEL_N_W = 29;
    localparam logic [LEVEL_N_W-1:0] N_VAL     = LEVEL_N_W'(90 * SECTOR_DEN_INT);
    localparam logic [LEVEL_N_W-1:0] N_LOW     = LEVEL_N_W'(9 * SECTOR_DEN_INT);
    localparam logic [LEVEL_N_W-1:0] HALF_TERM = LEVEL_N_W'(100 * SECTOR_DEN_INT);
    localparam logic [LEVEL_N_W-1:0] SLOPE     = LEVEL_N_W'(81);

    localparam int LVL_DIV     = 600;
    localparam int LVL_SHIFT   = 36;
    localparam int LVL_RECIP_W = 27;
    localparam logic [63:0] LVL_RECIP_FULL = (64'd1 << LVL_SHIFT) / 64'd600;
    localparam logic [LVL_RECIP_W-1:0] LVL_RECIP = LVL_RECIP_FULL[LVL_RECIP_W-1:0];

    localparam int PIPE_LATENCY = 3 + POS_W + 7;

    typedef struct packed {
        logic oor;
        logic rerr;
    } item_flags_t;

endpackage

`default_nettype wire

// ----- rtl/scalar_to_rgb_pseudocolor_unit.sv -----
// ----------------------------------------------------------------------------
// scalar_to_rgb_pseudocolor_unit
// Maps a signed fixed-point sample to a false color with a 0 to 200 degree
// hue ramp at saturation and value 0.9.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at each rising edge with start high and busy low. The
// unit is fully pipelined, so busy stays low and one item may enter every
// cycle. The result appears on red, green, blue, out_of_range and
// range_error for exactly one cycle with done high, in the order of entry.
// The pipeline is built around the restoring divider that forms the
// position in the range: one quotient bit per stage, 21 stages, plus three
// stages before it for clamping and seven after it for the hue sector, the
// reciprocal-multiply rounding and the output register.
// range_min and range_max are written through cfg_wr_en, cfg_addr and
// cfg_wdata, and take effect at once; the user is to change them only while
// no item is in flight, which the unit itself does not enforce. Reset
// empties the pipeline and sets the range to 0.0..1.0.
// The receiver has no way to stall the unit; each result must be taken in
// the cycle it is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_to_rgb_pseudocolor_unit #(
    parameter int VALUE_WIDTH = strgb_pkg::VALUE_WIDTH_DEF,
    parameter int COLOR_BITS  = strgb_pkg::COLOR_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [VALUE_WIDTH-1:0]   sample_value,
    input  wire logic                            cfg_wr_en,
    input  wire logic [strgb_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [VALUE_WIDTH-1:0]          cfg_wdata,
    output logic                                 done,
    output logic [COLOR_BITS-1:0]                red,
    output logic [COLOR_BITS-1:0]                green,
    output logic [COLOR_BITS-1:0]                blue,
    output logic                                 out_of_range,
    output logic                                 range_error
);

    import strgb_pkg::*;

    `include "scalar_to_rgb_pseudocolor_unit_assert.svh"

    localparam int W       = VALUE_WIDTH;
    localparam int FULL    = (2 ** COLOR_BITS) - 1;
    localparam int X_W     = COLOR_BITS + LEVEL_N_W + 2;
    localparam int Y_W     = X_W - POS_FRAC;
    localparam int PROD_W  = Y_W + LVL_RECIP_W;
    localparam int Q_W     = PROD_W - LVL_SHIFT;
    localparam logic [COLOR_BITS-1:0] LVL_V = COLOR_BITS'((180 * FULL + 100) / 200);
    localparam logic [COLOR_BITS-1:0] LVL_P = COLOR_BITS'((18 * FULL + 100) / 200);
    localparam logic [X_W-1:0] TWO_FULL = X_W'(2 * FULL);

    logic accept;

    logic signed [W-1:0] range_min_reg, range_min_next;
    logic signed [W-1:0] range_max_reg, range_max_next;

    logic                s1_valid_reg, s1_valid_next;
    logic signed [W-1:0] s1_sample_reg, s1_sample_next;

    logic                s2_valid_reg, s2_valid_next;
    logic signed [W-1:0] s2_clamp_reg, s2_clamp_next;
    item_flags_t         s2_flags_reg, s2_flags_next;

    logic                s3_valid_reg, s3_valid_next;
    logic [W-1:0]        s3_span_reg, s3_span_next;
    logic [W-1:0]        s3_dist_reg, s3_dist_next;
    item_flags_t         s3_flags_reg, s3_flags_next;

    logic                div_valid_reg [0:POS_FRAC];
    logic                div_valid_next [0:POS_FRAC];
    logic [POS_W-1:0]    div_q_reg [0:POS_FRAC];
    logic [POS_W-1:0]    div_q_next [0:POS_FRAC];
    logic [W-1:0]        div_rem_reg [0:POS_FRAC];
    logic [W-1:0]        div_rem_next [0:POS_FRAC];
    logic [W-1:0]        div_span_reg [0:POS_FRAC];
    logic [W-1:0]        div_span_next [0:POS_FRAC];
    item_flags_t         div_flags_reg [0:POS_FRAC];
    item_flags_t         div_flags_next [0:POS_FRAC];

    logic                pa_valid_reg, pa_valid_next;
    logic [HN_W-1:0]     pa_hn_reg, pa_hn_next;
    item_flags_t         pa_flags_reg, pa_flags_next;

    logic                pb_valid_reg, pb_valid_next;
    logic [SECTOR_W-1:0] pb_sector_reg, pb_sector_next;
    logic [REM_W-1:0]    pb_rem_reg, pb_rem_next;
    item_flags_t         pb_flags_reg, pb_flags_next;

    logic                 pc_valid_reg, pc_valid_next;
    logic [SECTOR_W-1:0]  pc_sector_reg, pc_sector_next;
    logic [LEVEL_N_W-1:0] pc_n_reg, pc_n_next;
    item_flags_t          pc_flags_reg, pc_flags_next;

    logic                pd_valid_reg, pd_valid_next;
    logic [SECTOR_W-1:0] pd_sector_reg, pd_sector_next;
    logic [Y_W-1:0]      pd_y_reg, pd_y_next;
    item_flags_t         pd_flags_reg, pd_flags_next;

    logic                pe_valid_reg, pe_valid_next;
    logic [SECTOR_W-1:0] pe_sector_reg, pe_sector_next;
    logic [Y_W-1:0]      pe_y_reg, pe_y_next;
    logic [PROD_W-1:0]   pe_prod_reg, pe_prod_next;
    item_flags_t         pe_flags_reg, pe_flags_next;

    logic                pf_valid_reg, pf_valid_next;
    logic [SECTOR_W-1:0] pf_sector_reg, pf_sector_next;
    logic [Q_W-1:0]      pf_q_reg, pf_q_next;
    logic                pf_inc_reg, pf_inc_next;
    item_flags_t         pf_flags_reg, pf_flags_next;

    logic                  done_reg, done_next;
    logic [COLOR_BITS-1:0] red_reg, red_next;
    logic [COLOR_BITS-1:0] green_reg, green_next;
    logic [COLOR_BITS-1:0] blue_reg, blue_next;
    logic                  oor_reg, oor_next;
    logic                  rerr_reg, rerr_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        range_min_next = range_min_reg;
        range_max_next = range_max_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_RANGE_MIN: range_min_next = cfg_wdata;
                REG_RANGE_MAX: range_max_next = cfg_wdata;
                default:
                begin
                    range_min_next = range_min_reg;
                    range_max_next = range_max_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        logic below;
        logic above;
        logic rerr;
        logic [W-1:0] span;
        logic [W-1:0] delta;

        s1_valid_next  = accept;
        s1_sample_next = sample_value;

        rerr  = range_max_reg <= range_min_reg;
        below = s1_sample_reg < range_min_reg;
        above = s1_sample_reg > range_max_reg;
        s2_valid_next      = s1_valid_reg;
        s2_flags_next.rerr = rerr;
        s2_flags_next.oor  = !rerr && (below || above);
        if (below)
        begin
            s2_clamp_next = range_min_reg;
        end
        else if (above)
        begin
            s2_clamp_next = range_max_reg;
        end
        else
        begin
            s2_clamp_next = s1_sample_reg;
        end

        span  = $unsigned(range_max_reg) - $unsigned(range_min_reg);
        delta = $unsigned(s2_clamp_reg) - $unsigned(range_min_reg);
        s3_valid_next = s2_valid_reg;
        s3_span_next  = span;
        s3_dist_next  = delta;
        s3_flags_next = s2_flags_reg;
    end

    always_comb
    begin
        logic ge;

        ge = s3_dist_reg >= s3_span_reg;
        div_valid_next[0] = s3_valid_reg;
        div_q_next[0]     = POS_W'(ge);
        div_rem_next[0]   = ge ? (s3_dist_reg - s3_span_reg) : s3_dist_reg;
        div_span_next[0]  = s3_span_reg;
        div_flags_next[0] = s3_flags_reg;
    end

    for (genvar k = 1; k <= POS_FRAC; k++)
    begin : g_div
        always_comb
        begin
            logic [W:0] shifted;
            logic [W:0] diff;
            logic       ge;

            shifted = {div_rem_reg[k-1], 1'b0};
            diff    = shifted - {1'b0, div_span_reg[k-1]};
            ge      = shifted >= {1'b0, div_span_reg[k-1]};
            div_valid_next[k] = div_valid_reg[k-1];
            div_q_next[k]     = {div_q_reg[k-1][POS_W-2:0], ge};
            div_rem_next[k]   = ge ? diff[W-1:0] : shifted[W-1:0];
            div_span_next[k]  = div_span_reg[k-1];
            div_flags_next[k] = div_flags_reg[k-1];
        end
    end

    always_comb
    begin
        logic [POS_W-1:0] pos;

        pos = div_q_reg[POS_FRAC];
        pa_valid_next = div_valid_reg[POS_FRAC];
        pa_hn_next    = HN_W'({pos, 3'b000}) + HN_W'({pos, 1'b0});
        pa_flags_next = div_flags_reg[POS_FRAC];

        pb_valid_next = pa_valid_reg;
        pb_flags_next = pa_flags_reg;
        if (pa_flags_reg.rerr)
        begin
            pb_sector_next = 2'd0;
            pb_rem_next    = '0;
        end
        else if (pa_hn_reg >= SECTOR_DEN_3)
        begin
            pb_sector_next = 2'd3;
            pb_rem_next    = REM_W'(pa_hn_reg - SECTOR_DEN_3);
        end
        else if (pa_hn_reg >= SECTOR_DEN_2)
        begin
            pb_sector_next = 2'd2;
            pb_rem_next    = REM_W'(pa_hn_reg - SECTOR_DEN_2);
        end
        else if (pa_hn_reg >= SECTOR_DEN_1)
        begin
            pb_sector_next = 2'd1;
            pb_rem_next    = REM_W'(pa_hn_reg - SECTOR_DEN_1);
        end
        else
        begin
            pb_sector_next = 2'd0;
            pb_rem_next    = REM_W'(pa_hn_reg);
        end
    end

    always_comb
    begin
        logic [LEVEL_N_W-1:0] ramp;
        logic [X_W-1:0]       x;

        ramp = LEVEL_N_W'(pb_rem_reg) * SLOPE;
        pc_valid_next  = pb_valid_reg;
        pc_sector_next = pb_sector_reg;
        pc_flags_next  = pb_flags_reg;
        pc_n_next      = pb_sector_reg[0] ? (N_VAL - ramp) : (N_LOW + ramp);

        x = X_W'(pc_n_reg) * TWO_FULL + X_W'(HALF_TERM);
        pd_valid_next  = pc_valid_reg;
        pd_sector_next = pc_sector_reg;
        pd_flags_next  = pc_flags_reg;
        pd_y_next      = x[X_W-1:POS_FRAC];

        pe_valid_next  = pd_valid_reg;
        pe_sector_next = pd_sector_reg;
        pe_flags_next  = pd_flags_reg;
        pe_y_next      = pd_y_reg;
        pe_prod_next   = PROD_W'(pd_y_reg) * PROD_W'(LVL_RECIP);
    end

    always_comb
    begin
        logic [Q_W-1:0] q_est;
        logic [Y_W-1:0] back;
        logic [Y_W-1:0] chk;

        q_est = pe_prod_reg[PROD_W-1:LVL_SHIFT];
        back  = Y_W'(q_est) * Y_W'(LVL_DIV);
        chk   = pe_y_reg - back;
        pf_valid_next  = pe_valid_reg;
        pf_sector_next = pe_sector_reg;
        pf_flags_next  = pe_flags_reg;
        pf_q_next      = q_est;
        pf_inc_next    = chk >= Y_W'(LVL_DIV);
    end

    always_comb
    begin
        logic [Q_W-1:0]        q_sum;
        logic [COLOR_BITS-1:0] lvl;

        q_sum = pf_q_reg + Q_W'(pf_inc_reg);
        lvl   = q_sum[COLOR_BITS-1:0];
        done_next = pf_valid_reg;
        oor_next  = pf_flags_reg.oor;
        rerr_next = pf_flags_reg.rerr;
        case (pf_sector_reg)
            2'd0:
            begin
                red_next   = LVL_V;
                green_next = lvl;
                blue_next  = LVL_P;
            end
            2'd1:
            begin
                red_next   = lvl;
                green_next = LVL_V;
                blue_next  = LVL_P;
            end
            2'd2:
            begin
                red_next   = LVL_P;
                green_next = LVL_V;
                blue_next  = lvl;
            end
            default:
            begin
                red_next   = LVL_P;
                green_next = lvl;
                blue_next  = LVL_V;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= W'(RANGE_MIN_RESET);
            range_max_reg <= W'(RANGE_MAX_RESET);
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            pa_valid_reg  <= 1'b0;
            pb_valid_reg  <= 1'b0;
            pc_valid_reg  <= 1'b0;
            pd_valid_reg  <= 1'b0;
            pe_valid_reg  <= 1'b0;
            pf_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            range_min_reg <= range_min_next;
            range_max_reg <= range_max_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            pa_valid_reg  <= pa_valid_next;
            pb_valid_reg  <= pb_valid_next;
            pc_valid_reg  <= pc_valid_next;
            pd_valid_reg  <= pd_valid_next;
            pe_valid_reg  <= pe_valid_next;
            pf_valid_reg  <= pf_valid_next;
            done_reg      <= done_next;
        end
    end

    for (genvar k = 0; k <= POS_FRAC; k++)
    begin : g_div_regs
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[k] <= 1'b0;
            end
            else
            begin
                div_valid_reg[k] <= div_valid_next[k];
            end
        end

        always_ff @(posedge clk)
        begin
            div_q_reg[k]     <= div_q_next[k];
            div_rem_reg[k]   <= div_rem_next[k];
            div_span_reg[k]  <= div_span_next[k];
            div_flags_reg[k] <= div_flags_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sample_reg <= s1_sample_next;
        s2_clamp_reg  <= s2_clamp_next;
        s2_flags_reg  <= s2_flags_next;
        s3_span_reg   <= s3_span_next;
        s3_dist_reg   <= s3_dist_next;
        s3_flags_reg  <= s3_flags_next;
        pa_hn_reg     <= pa_hn_next;
        pa_flags_reg  <= pa_flags_next;
        pb_sector_reg <= pb_sector_next;
        pb_rem_reg    <= pb_rem_next;
        pb_flags_reg  <= pb_flags_next;
        pc_sector_reg <= pc_sector_next;
        pc_n_reg      <= pc_n_next;
        pc_flags_reg  <= pc_flags_next;
        pd_sector_reg <= pd_sector_next;
        pd_y_reg      <= pd_y_next;
        pd_flags_reg  <= pd_flags_next;
        pe_sector_reg <= pe_sector_next;
        pe_y_reg      <= pe_y_next;
        pe_prod_reg   <= pe_prod_next;
        pe_flags_reg  <= pe_flags_next;
        pf_sector_reg <= pf_sector_next;
        pf_q_reg      <= pf_q_next;
        pf_inc_reg    <= pf_inc_next;
        pf_flags_reg  <= pf_flags_next;
        red_reg       <= red_next;
        green_reg     <= green_next;
        blue_reg      <= blue_next;
        oor_reg       <= oor_next;
        rerr_reg      <= rerr_next;
    end

    assign done         = done_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign out_of_range = oor_reg;
    assign range_error  = rerr_reg;

    `STRGB_ASSERT_IMPLY(a_latency, done, $past(start && !busy, PIPE_LATENCY),
        "result without an item taken at the pipeline latency before")
    `STRGB_ASSERT_IMPLY(a_rerr_no_oor, done && range_error, !out_of_range,
        "out_of_range set together with range_error")
    `STRGB_ASSERT_IMPLY(a_rerr_color, done && range_error,
        red == LVL_V && green == LVL_P && blue == LVL_P,
        "range error item did not give the hue-0 color")
    `STRGB_ASSERT_IMPLY(a_level_bounds, done,
        red >= LVL_P && red <= LVL_V && green >= LVL_P && green <= LVL_V &&
        blue >= LVL_P && blue <= LVL_V,
        "channel level outside the saturation and value bounds")
    `STRGB_ASSERT_NEXT(a_full_pos,
        div_valid_reg[0] && !div_flags_reg[0].rerr && div_q_reg[0][0],
        div_rem_reg[1] == '0 && div_q_reg[1][1:0] == 2'b10,
        "clamped sample beyond the top of the range reached the divider")

endmodule

`default_nettype wire
